// ----- hw/rtl/aabb_pairwise_overlap_macros.svh -----
// Assertion macros for the box overlap block
`ifndef AABB_PAIRWISE_OVERLAP_MACROS_SVH
`define AABB_PAIRWISE_OVERLAP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent in this cycle implies consequent in the same cycle
`define AABBPO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("overlap block: same-cycle check failed");

// Antecedent in this cycle implies consequent in the next cycle
`define AABBPO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("overlap block: next-cycle check failed");

`else

`define AABBPO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AABBPO_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/aabbpo_pkg.sv -----
// Shared constants for the box overlap block
package aabbpo_pkg;

  localparam int unsigned MaxBoxes   = 32;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned ExtBits    = 12;
  localparam int unsigned SlotBits   = 5;
  localparam int unsigned CountBits  = 6;
  localparam int unsigned MaskBits   = 32;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

endpackage

// ----- hw/rtl/aabbpo_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module aabbpo_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/aabbpo_hit_unit.sv -----
// Shared two-axis overlap test between the queried box and one stored box
module aabbpo_hit_unit #(
  parameter int unsigned COORD_BITS = aabbpo_pkg::CoordBits
) (
  input  logic [2*COORD_BITS+2*aabbpo_pkg::ExtBits-1:0] a_box_i,
  input  logic [2*COORD_BITS+2*aabbpo_pkg::ExtBits-1:0] b_box_i,
  output logic                                          hit_o
);

  localparam int unsigned EW = aabbpo_pkg::ExtBits;
  // Edge sums never wrap at this width
  localparam int unsigned SW = ((COORD_BITS > EW) ? COORD_BITS : EW + 1) + 1;

  logic signed [SW-1:0] ax, ay, bx, by;
  logic signed [SW-1:0] aw, ah, bw, bh;
  logic                 hit_x, hit_y;

  // Layout: {x, y, width, height}
  assign ax = SW'($signed(a_box_i[2*COORD_BITS+2*EW-1 -: COORD_BITS]));
  assign ay = SW'($signed(a_box_i[COORD_BITS+2*EW-1 -: COORD_BITS]));
  assign aw = $signed(SW'(a_box_i[2*EW-1 -: EW]));
  assign ah = $signed(SW'(a_box_i[EW-1:0]));
  assign bx = SW'($signed(b_box_i[2*COORD_BITS+2*EW-1 -: COORD_BITS]));
  assign by = SW'($signed(b_box_i[COORD_BITS+2*EW-1 -: COORD_BITS]));
  assign bw = $signed(SW'(b_box_i[2*EW-1 -: EW]));
  assign bh = $signed(SW'(b_box_i[EW-1:0]));

  // Start of one lies in [start, end) of the other
  assign hit_x = ((bx >= ax) && (bx < ax + aw)) || ((ax >= bx) && (ax < bx + bw));
  assign hit_y = ((by >= ay) && (by < ay + ah)) || ((ay >= by) && (ay < by + bh));
  assign hit_o = hit_x && hit_y;

endmodule

// ----- hw/rtl/aabb_pairwise_overlap.sv -----
// Box overlap table: sequencer, box RAM and shared overlap test
// Sequence: a write gives no result. A query with active slots holds its box in S_QLOAD,
//   scans min(active_count, MAX_BOXES, 32) slots in S_SCAN, then raises the registered done_o.
// Throughput: one RAM read port walks the table one slot per cycle; busy is high
//   while a query loads and scans, and the next item may start in the strobe cycle.
// Reset: rst_ni clears the sequencer and active_count; box contents are undefined
//   until written. The receiver cannot stall; done_o lasts exactly one cycle.
`include "aabb_pairwise_overlap_macros.svh"

module aabb_pairwise_overlap #(
  parameter int unsigned MAX_BOXES  = aabbpo_pkg::MaxBoxes,
  parameter int unsigned COORD_BITS = aabbpo_pkg::CoordBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind_i,
  input  logic [aabbpo_pkg::SlotBits-1:0]        slot_i,
  input  logic signed [COORD_BITS-1:0]           pos_x_i,
  input  logic signed [COORD_BITS-1:0]           pos_y_i,
  input  logic [aabbpo_pkg::ExtBits-1:0]         box_width_i,
  input  logic [aabbpo_pkg::ExtBits-1:0]         box_height_i,
  // result strobe
  output logic                                   done_o,
  output logic [aabbpo_pkg::MaskBits-1:0]        overlap_mask_o,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [aabbpo_pkg::CountBits-1:0]       cfg_data_i
);

  localparam int unsigned BOX_W = 2*COORD_BITS + 2*aabbpo_pkg::ExtBits;
  localparam int unsigned AW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW    = aabbpo_pkg::CountBits;
  localparam int unsigned IW    = aabbpo_pkg::SlotBits;
  localparam int unsigned MW    = aabbpo_pkg::MaskBits;
  // Slots that can take part: bounded by the table and the mask width
  localparam int unsigned LIMIT = (MAX_BOXES < MW) ? MAX_BOXES : MW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QLOAD,
    S_SCAN
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      active_count_q;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      slot_q, slot_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [MW-1:0]      mask_q, mask_d;
  logic               done_q, done_d;
  logic [BOX_W-1:0]   qbox_q, qbox_d;

  logic               accept;
  logic               slot_ok;
  logic [CW-1:0]      count_clamped;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [BOX_W-1:0]   ram_rdata;
  logic               hit;

  assign accept  = start && !busy;
  assign slot_ok = (32'(slot_i) < MAX_BOXES);
  assign count_clamped = (32'(active_count_q) > LIMIT) ? CW'(LIMIT) : active_count_q;

  // Writes go straight to the RAM in the transfer cycle
  assign ram_we = accept && (kind_i == aabbpo_pkg::KindWrite) && slot_ok;

  aabbpo_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(slot_i)),
    .wdata_i ({pos_x_i, pos_y_i, box_width_i, box_height_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Queried box against the entry whose read data is present this cycle
  aabbpo_hit_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_hit (
    .a_box_i (qbox_q),
    .b_box_i (ram_rdata),
    .hit_o   (hit)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    mask_d    = mask_q;
    qbox_d    = qbox_q;
    done_d    = 1'b0;
    ram_raddr = AW'(slot_i);

    case (state_q)
      S_IDLE: begin
        // Read the queried slot in the transfer cycle
        ram_raddr = AW'(slot_i);
        if (accept && (kind_i == aabbpo_pkg::KindQuery)) begin
          slot_d  = slot_i;
          count_d = count_clamped;
          idx_d   = '0;
          mask_d  = '0;
          if (!slot_ok || (count_clamped == '0)) begin
            // Nothing to scan: answer with an empty mask at once
            done_d = 1'b1;
          end else begin
            state_d = S_QLOAD;
          end
        end
      end
      S_QLOAD: begin
        // Hold the queried box and start the sweep at slot 0
        qbox_d    = ram_rdata;
        ram_raddr = '0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        ram_raddr = AW'(idx_q + IW'(1));
        if (hit && (idx_q != slot_q)) begin
          mask_d = mask_q | (MW'(1) << idx_q);
        end
        if (CW'(idx_q) == count_q - CW'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      slot_q  <= '0;
      idx_q   <= '0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      count_q <= count_d;
      slot_q  <= slot_d;
      idx_q   <= idx_d;
      mask_q  <= mask_d;
    end
  end

  // Query box register carries payload only
  always_ff @(posedge clk_i) begin
    qbox_q <= qbox_d;
  end

  // Active slot count, written over its own channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_count_q <= cfg_data_i;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = !busy;
  assign done_o         = done_q;
  assign overlap_mask_o = mask_q;

  // No strobe while the scan still runs
  `AABBPO_ASSERT_SAME(a_no_done_busy, clk_i, rst_ni, busy, !done_o)
  // A write transfer never causes a result
  `AABBPO_ASSERT_NEXT(a_write_silent, clk_i, rst_ni,
                      start && !busy && (kind_i == aabbpo_pkg::KindWrite), !done_o)
  // A query transfer either starts a scan or answers at once
  `AABBPO_ASSERT_NEXT(a_query_moves, clk_i, rst_ni,
                      start && !busy && (kind_i == aabbpo_pkg::KindQuery), busy || done_o)
  // The queried slot never reports itself
  `AABBPO_ASSERT_SAME(a_no_self, clk_i, rst_ni, done_o, !overlap_mask_o[slot_q])

endmodule
